### rtl/pso_pkg.sv
`default_nettype none

package pso_pkg;

  // width of the signed working values (moves, sums before wrap or clamp)
  localparam int V_W = 44;
  localparam int OFF_W = 24;

  localparam logic [V_W-1:0] MAG_CAP = 44'h100_0000_0000;
  localparam logic [OFF_W-1:0] OFF_MAX = 24'hFF_FFFF;
  localparam logic [15:0] SW_MAX = 16'hFFFF;
  localparam logic [8:0] PAR_ONE = 9'd256;

  // reset values of the register file
  localparam logic       RST_REPEAT_MODE = 1'b1;
  localparam logic [8:0]  RST_PARALLAX   = 9'd128;
  localparam logic [11:0] RST_FRAME_W    = 12'd800;
  localparam logic [11:0] RST_FRAME_H    = 12'd600;
  localparam logic [15:0] RST_SCROLL_SPD = 16'd100;

  typedef enum logic [2:0] {
    CFG_REPEAT_MODE,
    CFG_PARALLAX_FACTOR,
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_TEXTURE_WIDTH,
    CFG_TEXTURE_HEIGHT,
    CFG_MAX_SPEED,
    CFG_SCROLL_SPEED
  } cfg_idx_t;

  typedef struct packed {
    logic        repeat_mode;
    logic [8:0]  parallax_factor;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [11:0] texture_width;
    logic [11:0] texture_height;
    logic [15:0] max_speed;
    logic [15:0] scroll_speed;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SW,
    S_SW_WAIT,
    S_DECIDE,
    S_CSNAP_WAIT,
    S_CMOVE_WAIT,
    S_STEP,
    S_ADD,
    S_WRAP,
    S_MOD_WAIT,
    S_CLAMP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### rtl/pso_cfg.sv
`default_nettype none

module pso_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_wdata,
  output pso_pkg::cfg_t      cfg,
  output logic               cam_clr
);
  import pso_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_mode     <= RST_REPEAT_MODE;
      cfg_r.parallax_factor <= RST_PARALLAX;
      cfg_r.frame_width     <= RST_FRAME_W;
      cfg_r.frame_height    <= RST_FRAME_H;
      cfg_r.texture_width   <= '0;
      cfg_r.texture_height  <= '0;
      cfg_r.max_speed       <= '0;
      cfg_r.scroll_speed    <= RST_SCROLL_SPD;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REPEAT_MODE:     cfg_r.repeat_mode     <= cfg_wdata[0];
        CFG_PARALLAX_FACTOR: cfg_r.parallax_factor <= cfg_wdata[8:0];
        CFG_FRAME_WIDTH:     cfg_r.frame_width     <= cfg_wdata[11:0];
        CFG_FRAME_HEIGHT:    cfg_r.frame_height    <= cfg_wdata[11:0];
        CFG_TEXTURE_WIDTH:   cfg_r.texture_width   <= cfg_wdata[11:0];
        CFG_TEXTURE_HEIGHT:  cfg_r.texture_height  <= cfg_wdata[11:0];
        CFG_MAX_SPEED:       cfg_r.max_speed       <= cfg_wdata;
        CFG_SCROLL_SPEED:    cfg_r.scroll_speed    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // geometry writes force a fresh camera snap
  always_comb begin
    cam_clr = 1'b0;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT,
        CFG_TEXTURE_WIDTH, CFG_TEXTURE_HEIGHT: cam_clr = 1'b1;
        default: cam_clr = 1'b0;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/pso_div.sv
`default_nettype none

module pso_div #(
  parameter int NUM_W = 57,
  parameter int DEN_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo,
  output logic [DEN_W-1:0]      rem
);
  import pso_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

### rtl/parallax_scroll_offset.sv
`default_nettype none

// background scroll offset for a parallax layer. each word is either a camera
// update (action 0) or a time tick (action 1) and yields exactly one result word
// carrying the new offset (unsigned, FRACTION_BITS fraction bits), the scaled
// background width and the largest clamp offset. a single restoring divider
// (one quotient bit a cycle, 49 + FRACTION_BITS steps) does the scaled width,
// the clamp-mode scaling and the wrap modulo. a word with no texture height
// uses no divide; zero camera changes, zero scroll speed, clamp snaps to the
// range ends and clamp-mode ticks use only the scaled width divide; a scaled
// clamp snap, wrapped results and scaled clamp moves need a second divide. the
// input is ready only while the sequencer is idle; a finished result sits in
// the output register, so the next word is taken while it waits, and a result
// still waiting there when the next one is done holds the sequencer until it
// leaves
module parallax_scroll_offset #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [31:0] in_camera_x,
  input  wire logic [31:0] in_camera_range,
  input  wire logic [15:0] in_delta_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [23:0]      out_offset,
  output logic [15:0]      out_scaled_width,
  output logic [15:0]      out_offset_limit,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import pso_pkg::*;

  localparam int WQ_W  = 16 + FRACTION_BITS;   // scaled width in fixed point
  localparam int NUM_W = 33 + WQ_W;            // |camera change| times limit
  localparam int DEN_W = 32;
  localparam int SH    = 16 - FRACTION_BITS;   // dt products back to offset scale

  cfg_t cfg;
  logic cam_clr;

  // state
  state_t state_r, state_nxt;

  // latched word
  logic        act_r, act_nxt;
  logic [31:0] cam_r, cam_nxt;
  logic [31:0] rng_r, rng_nxt;
  logic [15:0] dt_r, dt_nxt;

  // geometry and working values
  logic [15:0]            sw_r, sw_nxt;
  logic [15:0]            lim_r, lim_nxt;
  logic [31:0]            step_r, step_nxt;
  logic signed [V_W-1:0]  prod_r, prod_nxt;
  logic signed [V_W-1:0]  v_r, v_nxt;
  logic                   neg_r, neg_nxt;

  // architectural state
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [31:0]      last_r, last_nxt;
  logic             cam_vld_r, cam_vld_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0] out_off_r, out_off_nxt;
  logic [15:0]      out_sw_r, out_sw_nxt;
  logic [15:0]      out_lim_r, out_lim_nxt;

  // divider port
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;
  logic [DEN_W-1:0] div_rem;

  // datapath terms
  logic [WQ_W-1:0]       wq;
  logic [WQ_W-1:0]       lq;
  logic [8:0]            par_eff;
  logic [23:0]           area;
  logic [15:0]           sw_sat;
  logic signed [41:0]    cp;
  logic signed [32:0]    delta;
  logic signed [42:0]    dp;
  logic signed [32:0]    tp;
  logic [31:0]           sp;
  logic [32:0]           dmag;
  logic [32:0]           mul_a;
  logic [NUM_W-1:0]      mp;
  logic [V_W-1:0]        v_abs;
  logic signed [V_W-1:0] step_s;
  logic signed [V_W-1:0] move;
  logic signed [V_W-1:0] lq_s;
  logic [V_W-1:0]        mag;
  logic [DEN_W-1:0]      mod_res;

  function automatic logic [OFF_W-1:0] sat_off(input logic [V_W-1:0] x);
    return (x > V_W'(OFF_MAX)) ? OFF_MAX : x[OFF_W-1:0];
  endfunction

  pso_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .cam_clr   (cam_clr)
  );

  pso_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_comb begin
    wq      = {sw_r, {FRACTION_BITS{1'b0}}};
    lq      = {lim_r, {FRACTION_BITS{1'b0}}};
    lq_s    = $signed(V_W'(lq));
    par_eff = (cfg.parallax_factor > PAR_ONE) ? PAR_ONE : cfg.parallax_factor;
    area    = cfg.texture_width * cfg.frame_height;
    sw_sat  = (div_quo > NUM_W'(SW_MAX)) ? SW_MAX : div_quo[15:0];
    cp      = $signed(cam_r) * $signed({1'b0, par_eff});
    delta   = $signed({cam_r[31], cam_r}) - $signed({last_r[31], last_r});
    dp      = delta * $signed({1'b0, par_eff});
    tp      = $signed(cfg.scroll_speed) * $signed({1'b0, dt_r});
    sp      = {16'b0, cfg.max_speed} * {16'b0, dt_r};
    dmag    = delta[32] ? 33'(-delta) : 33'(delta);
    // one multiplier serves the clamp snap and the clamp move
    mul_a   = cam_vld_r ? dmag : {1'b0, cam_r};
    mp      = NUM_W'(mul_a) * NUM_W'(lq);
    v_abs   = v_r[V_W-1] ? V_W'(-v_r) : V_W'(v_r);
    step_s  = $signed(V_W'(step_r));
    mag     = (div_quo > NUM_W'(MAG_CAP)) ? MAG_CAP : V_W'(div_quo);
    mod_res = (neg_r && (div_rem != '0)) ? (DEN_W'(wq) - div_rem) : div_rem;
    move    = prod_r;
    if (cfg.max_speed != '0) begin
      if (prod_r > step_s) begin
        move = step_s;
      end else if (prod_r < -step_s) begin
        move = -step_s;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    cam_nxt       = cam_r;
    rng_nxt       = rng_r;
    dt_nxt        = dt_r;
    sw_nxt        = sw_r;
    lim_nxt       = lim_r;
    step_nxt      = step_r;
    prod_nxt      = prod_r;
    v_nxt         = v_r;
    neg_nxt       = neg_r;
    off_nxt       = off_r;
    last_nxt      = last_r;
    cam_vld_nxt   = cam_vld_r;
    out_valid_nxt = out_valid_r;
    out_off_nxt   = out_off_r;
    out_sw_nxt    = out_sw_r;
    out_lim_nxt   = out_lim_r;
    div_start     = 1'b0;
    div_num       = mp;
    div_den       = rng_r;
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_nxt   = in_action;
          cam_nxt   = in_camera_x;
          rng_nxt   = in_camera_range;
          dt_nxt    = in_delta_time;
          state_nxt = S_SW;
        end
      end

      // scaled width = texture width * frame height / texture height
      S_SW: begin
        if (cfg.texture_height == '0) begin
          sw_nxt    = '0;
          lim_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          div_num   = NUM_W'(area);
          div_den   = DEN_W'(cfg.texture_height);
          state_nxt = S_SW_WAIT;
        end
      end

      S_SW_WAIT: begin
        if (div_done) begin
          sw_nxt    = sw_sat;
          lim_nxt   = (sw_sat > 16'(cfg.frame_width)) ? sw_sat - 16'(cfg.frame_width) : '0;
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        step_nxt = sp >> SH;
        if (sw_r == '0) begin
          // no background: nothing moves
          state_nxt = S_DONE;
        end else if (act_r) begin
          if (cfg.scroll_speed == '0) begin
            state_nxt = S_DONE;
          end else begin
            prod_nxt  = $signed(V_W'(tp >>> SH));
            state_nxt = S_ADD;
          end
        end else if (!cam_vld_r) begin
          // first camera word: snap
          last_nxt    = cam_r;
          cam_vld_nxt = 1'b1;
          if (cfg.repeat_mode) begin
            v_nxt     = $signed(V_W'(cp)) >>> 8;
            state_nxt = S_WRAP;
          end else if ($signed(rng_r) <= 0 || lim_r == '0 || $signed(cam_r) <= 0) begin
            off_nxt   = '0;
            state_nxt = S_DONE;
          end else if ($signed(cam_r) >= $signed(rng_r)) begin
            off_nxt   = sat_off(V_W'(lq));
            state_nxt = S_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = S_CSNAP_WAIT;
          end
        end else begin
          last_nxt = cam_r;
          if (delta == '0) begin
            state_nxt = S_DONE;
          end else if (cfg.repeat_mode) begin
            prod_nxt  = $signed(V_W'(dp)) >>> 8;
            state_nxt = S_STEP;
          end else if ($signed(rng_r) <= 0 || lim_r == '0) begin
            off_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            neg_nxt   = delta[32];
            div_start = 1'b1;
            state_nxt = S_CMOVE_WAIT;
          end
        end
      end

      S_CSNAP_WAIT: begin
        if (div_done) begin
          off_nxt   = sat_off(V_W'(div_quo));
          state_nxt = S_DONE;
        end
      end

      // scaled clamp move, rounded toward zero
      S_CMOVE_WAIT: begin
        if (div_done) begin
          prod_nxt  = neg_r ? -$signed(mag) : $signed(mag);
          state_nxt = S_STEP;
        end
      end

      // speed limit on camera driven moves
      S_STEP: begin
        v_nxt     = $signed(V_W'(off_r)) + move;
        state_nxt = cfg.repeat_mode ? S_WRAP : S_CLAMP;
      end

      S_ADD: begin
        v_nxt     = $signed(V_W'(off_r)) + prod_r;
        state_nxt = cfg.repeat_mode ? S_WRAP : S_CLAMP;
      end

      // modulo of the magnitude, folded back for negative values
      S_WRAP: begin
        neg_nxt   = v_r[V_W-1];
        div_start = 1'b1;
        div_num   = NUM_W'(v_abs);
        div_den   = DEN_W'(wq);
        state_nxt = S_MOD_WAIT;
      end

      S_MOD_WAIT: begin
        if (div_done) begin
          off_nxt   = sat_off(V_W'(mod_res));
          state_nxt = S_DONE;
        end
      end

      S_CLAMP: begin
        if (v_r < 0) begin
          off_nxt = '0;
        end else if (v_r > lq_s) begin
          off_nxt = sat_off(V_W'(lq));
        end else begin
          off_nxt = sat_off(V_W'(v_r));
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_off_nxt   = off_r;
          out_sw_nxt    = sw_r;
          out_lim_nxt   = lim_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (cam_clr) begin
      cam_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      off_r       <= '0;
      last_r      <= '0;
      cam_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      off_r       <= off_nxt;
      last_r      <= last_nxt;
      cam_vld_r   <= cam_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    cam_r     <= cam_nxt;
    rng_r     <= rng_nxt;
    dt_r      <= dt_nxt;
    sw_r      <= sw_nxt;
    lim_r     <= lim_nxt;
    step_r    <= step_nxt;
    prod_r    <= prod_nxt;
    v_r       <= v_nxt;
    neg_r     <= neg_nxt;
    out_off_r <= out_off_nxt;
    out_sw_r  <= out_sw_nxt;
    out_lim_r <= out_lim_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_offset       = out_off_r;
  assign out_scaled_width = out_sw_r;
  assign out_offset_limit = out_lim_r;

endmodule

`default_nettype wire
